[design/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants for the PUCT child selector
// Widths of the item fields and the word that passes from front to back.
// ----------------------------------------------------------------------------
`default_nettype none
package pcs_pkg;
  localparam int unsigned MaxChildrenDefault = 256;
  localparam int unsigned VisitBitsDefault   = 20;
  localparam int unsigned VsumW  = 37;
  localparam int unsigned VisW   = 20;
  localparam int unsigned PriorW = 17;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned ScoreW = 32;
  localparam logic [CfgW-1:0] CfgReset = 16'd4096;

  // One child word, as handed from the front to the back.
  typedef struct packed {
    logic signed [VsumW-1:0] vsum;
    logic [31:0]             visits;
    logic [PriorW-1:0]       prior;
    logic [31:0]             parent;
    logic                    score_it;
    logic                    last;
  } child_t;
endpackage
`default_nettype wire

[design/puct_child_select_core.sv]
// ----------------------------------------------------------------------------
// puct_child_select_core: PUCT child selection
// Scores a node's children one by one and reports the best one per node.
// ----------------------------------------------------------------------------
// One word per child enters a two-entry queue, and the input stalls while both
// entries are taken. The back end takes a scored child through a pick-up step,
// the bit-serial square root (24 steps), two multiplies, the exploration divide
// (a load and 37 steps), the q divide (54 steps) and a decision step. Children
// past MAX_CHILDREN go from pick-up straight to the decision step. On the child
// marked last, one result word rises in the cycle after its decision step and
// holds while the output stalls; it carries the winner's arrival index and its
// saturated Q15.16 score; ties keep the earlier child. The user must write
// exploration_constant via cfg_we_i only while idle, which is not enforced.
`default_nettype none
module puct_child_select_core #(
  parameter int unsigned MAX_CHILDREN = pcs_pkg::MaxChildrenDefault,
  parameter int unsigned VISIT_BITS   = pcs_pkg::VisitBitsDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [pcs_pkg::CfgW-1:0]         cfg_wdata_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic signed [pcs_pkg::VsumW-1:0] child_value_sum_i,
  input  wire logic [VISIT_BITS-1:0]            child_visits_i,
  input  wire logic [pcs_pkg::PriorW-1:0]       child_prior_i,
  input  wire logic [VISIT_BITS-1:0]            parent_visits_i,
  input  wire logic                             last_child_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [pcs_pkg::IdxW-1:0]              best_index_o,
  output logic signed [pcs_pkg::ScoreW-1:0]     win_score_o
);
  logic [pcs_pkg::CfgW-1:0] cfg_q;
  logic q_valid, q_pop;
  pcs_pkg::child_t q_word;

  // The exploration weight register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pcs_pkg::CfgReset;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  pcs_front #(.MAX_CHILDREN(MAX_CHILDREN), .VISIT_BITS(VISIT_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid(in_valid_i), .in_stall(in_stall_o),
    .child_value_sum_i, .child_visits_i, .child_prior_i, .parent_visits_i,
    .last_child_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_word_o(q_word)
  );

  pcs_back u_back (
    .clk_i, .rst_ni, .cfg_c_i(cfg_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_word_i(q_word),
    .out_valid(out_valid_o), .out_stall(out_stall_i),
    .best_index_o, .win_score_o
  );
endmodule
`default_nettype wire

[design/pcs_front.sv]
// ----------------------------------------------------------------------------
// pcs_front: input acceptance and classification
// Counts children in a group, marks those past the limit as not scored, and
// pushes each word into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_front #(
  parameter int unsigned MAX_CHILDREN = pcs_pkg::MaxChildrenDefault,
  parameter int unsigned VISIT_BITS   = pcs_pkg::VisitBitsDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [pcs_pkg::VsumW-1:0] child_value_sum_i,
  input  wire logic [VISIT_BITS-1:0]          child_visits_i,
  input  wire logic [pcs_pkg::PriorW-1:0]     child_prior_i,
  input  wire logic [VISIT_BITS-1:0]          parent_visits_i,
  input  wire logic                           last_child_i,
  output logic                                q_valid_o,
  input  wire logic                           q_pop_i,
  output pcs_pkg::child_t                     q_word_o
);
  localparam int unsigned PosW = $clog2(MAX_CHILDREN + 1);
  logic [PosW-1:0] pos_q, pos_d;
  pcs_pkg::child_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic push, pop;
  pcs_pkg::child_t w;

  assign in_stall = (cnt_q == 2'd2);
  assign push = in_valid && !in_stall;
  assign pop  = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_word_o  = mem_q[rp_q];

  always_comb begin
    w = '0;
    w.vsum     = child_value_sum_i;
    w.visits   = 32'(child_visits_i);
    w.prior    = child_prior_i;
    w.parent   = 32'(parent_visits_i);
    w.score_it = (pos_q < PosW'(MAX_CHILDREN));
    w.last     = last_child_i;
    pos_d = pos_q;
    if (last_child_i) begin
      pos_d = '0;
    end else if (w.score_it) begin
      pos_d = pos_q + PosW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        pos_q <= pos_d;
        wp_q  <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= w;
    end
  end
endmodule
`default_nettype wire

[design/pcs_back.sv]
// ----------------------------------------------------------------------------
// pcs_back: score evaluation and running best
// A sequencer computes the square root, q and the exploration term with
// bit-serial units, then updates the running best and emits on the last child.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [pcs_pkg::CfgW-1:0]       cfg_c_i,
  input  wire logic                           q_valid_i,
  output logic                                q_pop_o,
  input  pcs_pkg::child_t                     q_word_i,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [pcs_pkg::IdxW-1:0]            best_index_o,
  output logic signed [pcs_pkg::ScoreW-1:0]   win_score_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SQRT = 3'd1, S_MUL1 = 3'd2, S_MUL2 = 3'd3,
                         S_DIV = 3'd4, S_QDIV = 3'd5, S_DONE = 3'd6, S_OUT = 3'd7;
  logic [2:0] st_q;
  pcs_pkg::child_t cw_q;
  logic [5:0] cnt_q;
  // Square root: radicand up to 48 bits, root up to 24 bits.
  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [32:0] prod1_q;   // c * prior
  logic [56:0] prod2_q;   // c * prior * root
  logic [56:0] num_q;
  logic [56:0] quo_q;
  logic [57:0] drem_q;
  logic [32:0] den_q;
  // q division: numerator magnitude up to 54 bits, divisor 33 bits.
  logic [53:0] qn_q;
  logic [53:0] qq_q;
  logic [33:0] qr_q;
  logic        qneg_q;
  logic signed [31:0] best_q;
  logic [7:0]  bidx_q;
  logic [8:0]  pos_q;
  logic        started_q;
  logic [7:0]  oidx_q;
  logic signed [31:0] osc_q;

  logic [25:0] trial;
  logic [25:0] rem_sh;
  logic [57:0] dr_sh;
  logic [33:0] qr_sh;
  logic signed [55:0] qnum;
  logic signed [58:0] total;
  logic signed [55:0] qval;
  logic signed [31:0] sat;

  always_comb begin
    rem_sh = {rem_q[23:0], rad_q[47:46]};
    trial  = {root_q, 2'b01};
    dr_sh  = {drem_q[56:0], num_q[56]};
    qr_sh  = {qr_q[32:0], qn_q[53]};
    qnum   = (56'(signed'({1'b0, cw_q.visits})) <<< 16) - 56'(cw_q.vsum);
    if (cw_q.visits == 32'd0) begin
      qval = 56'sd32768;
    end else if (qneg_q) begin
      qval = -56'(signed'({1'b0, qq_q})) - ((qr_q != '0) ? 56'sd1 : 56'sd0);
    end else begin
      qval = 56'(signed'({1'b0, qq_q}));
    end
    total = 59'(qval) + 59'(signed'({1'b0, quo_q}));
    if (total > 59'sd2147483647) begin
      sat = 32'h7fffffff;
    end else if (total < -59'sd2147483648) begin
      sat = 32'h80000000;
    end else begin
      sat = total[31:0];
    end
  end

  assign q_pop_o      = (st_q == S_IDLE) && q_valid_i;
  assign out_valid    = (st_q == S_OUT);
  assign best_index_o = oidx_q;
  assign win_score_o  = osc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= S_IDLE;
      best_q    <= '0;
      bidx_q    <= '0;
      pos_q     <= '0;
      started_q <= 1'b0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            st_q <= q_word_i.score_it ? S_SQRT : S_DONE;
          end
        end
        S_SQRT: begin
          if (cnt_q == 6'd23) st_q <= S_MUL1;
        end
        S_MUL1: st_q <= S_MUL2;
        S_MUL2: st_q <= S_DIV;
        S_DIV: begin
          if (cnt_q == 6'd37) st_q <= S_QDIV;
        end
        S_QDIV: begin
          if (cnt_q == 6'd53) st_q <= S_DONE;
        end
        S_DONE: begin
          if (cw_q.last) begin
            st_q      <= S_OUT;
            best_q    <= '0;
            bidx_q    <= '0;
            pos_q     <= '0;
            started_q <= 1'b0;
          end else begin
            st_q <= S_IDLE;
            if (cw_q.score_it) begin
              if (!started_q || sat > best_q) begin
                best_q <= sat;
                bidx_q <= pos_q[7:0];
              end
              started_q <= 1'b1;
              pos_q     <= pos_q + 9'd1;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        cw_q   <= q_word_i;
        cnt_q  <= '0;
        rad_q  <= {q_word_i.parent, 16'd0};
        rem_q  <= '0;
        root_q <= '0;
      end
      S_SQRT: begin
        rad_q <= {rad_q[45:0], 2'b00};
        cnt_q <= cnt_q + 6'd1;
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[22:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[22:0], 1'b0};
        end
      end
      S_MUL1: begin
        prod1_q <= 33'(cfg_c_i) * 33'(cw_q.prior);
      end
      S_MUL2: begin
        prod2_q <= 57'(prod1_q) * 57'(root_q);
        cnt_q   <= '0;
      end
      S_DIV: begin
        if (cnt_q == 6'd0) begin
          num_q  <= prod2_q;
          drem_q <= '0;
          den_q  <= 33'(cw_q.visits) + 33'd1;
          quo_q  <= '0;
          cnt_q  <= 6'd1;
        end else begin
          // Divide by (visits+1) << 20: only the 37 bits from bit 20 upward are
          // shifted through, so the quotient is (prod >> 20) / (visits+1).
          num_q <= {num_q[55:0], 1'b0};
          if (dr_sh >= {25'd0, den_q}) begin
            drem_q <= dr_sh - {25'd0, den_q};
            quo_q  <= {quo_q[55:0], 1'b1};
          end else begin
            drem_q <= dr_sh;
            quo_q  <= {quo_q[55:0], 1'b0};
          end
          if (cnt_q == 6'd37) begin
            cnt_q  <= '0;
            qneg_q <= qnum[55];
            qn_q   <= qnum[55] ? 54'(-qnum) : 54'(qnum);
            qr_q   <= '0;
            qq_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
      end
      S_QDIV: begin
        qn_q  <= {qn_q[52:0], 1'b0};
        cnt_q <= cnt_q + 6'd1;
        if (qr_sh >= {cw_q.visits, 1'b0}) begin
          qr_q <= qr_sh - {1'b0, cw_q.visits, 1'b0};
          qq_q <= {qq_q[52:0], 1'b1};
        end else begin
          qr_q <= qr_sh;
          qq_q <= {qq_q[52:0], 1'b0};
        end
      end
      S_DONE: begin
        if (cw_q.score_it && (!started_q || sat > best_q)) begin
          oidx_q <= pos_q[7:0];
          osc_q  <= sat;
        end else begin
          oidx_q <= bidx_q;
          osc_q  <= best_q;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

[design/pcs_checker.sv]
// ----------------------------------------------------------------------------
// pcs_checker: port-level checks for the PUCT child selector
// Watches the handshakes on the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none
module pcs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [7:0]  best_index_o,
  input wire logic [31:0] win_score_o,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o
);
  // A result word holds while stalled.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(win_score_o)
      && $stable(best_index_o)) else $error("result word changed under stall");
  // A result drops in the cycle after it is taken.
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |=> !out_valid_o) else $error("result repeated");
  // The input queue is never full right after reset.
  a_rst_ready: assert property (@(posedge clk_i)
    !rst_ni |=> !in_stall_o) else $error("stall out of reset");
  // A stalled input word stays offered.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i) else $error("input word withdrawn");
endmodule

bind puct_child_select_core pcs_checker u_pcs_checker (
  .clk_i, .rst_ni, .out_valid_o, .out_stall_i, .best_index_o, .win_score_o,
  .in_valid_i, .in_stall_o
);
`default_nettype wire
